FILE: hdl/atoi_pkg.sv
package atoi_pkg;

  // maximum count of consumed characters
  localparam logic [11:0] MAX_CHARS = 12'd4095;

  // character queue between front and back
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QAW    = $clog2(QDEPTH);

  // radix limits and fixed radixes
  localparam logic [5:0] BASE_AUTO = 6'd0;
  localparam logic [5:0] BASE_ONE  = 6'd1;
  localparam logic [5:0] BASE_MAX  = 6'd36;
  localparam logic [5:0] BASE_OCT  = 6'd8;
  localparam logic [5:0] BASE_DEC  = 6'd10;
  localparam logic [5:0] BASE_HEX  = 6'd16;
  localparam logic [5:0] NO_DIGIT  = 6'd36;

  // characters
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LZ    = 8'h7a;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UZ    = 8'h5a;
  localparam logic [7:0] CH_LX    = 8'h78;
  localparam logic [7:0] CH_UX    = 8'h58;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0d;

  // configuration register indexes
  localparam logic CFG_NUMBER_BASE = 1'b0;
  localparam logic CFG_SIGNED_MODE = 1'b1;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BAD_BASE = 2'd1,
    ST_RANGE    = 2'd2
  } status_e;

  typedef enum logic [6:0] {
    PH_FRESH  = 7'b0000001,
    PH_SPACE  = 7'b0000010,
    PH_SIGNED = 7'b0000100,
    PH_ZERO   = 7'b0001000,
    PH_PREFIX = 7'b0010000,
    PH_DIGITS = 7'b0100000,
    PH_DONE   = 7'b1000000
  } phase_e;

  // one classified character
  typedef struct packed {
    logic [5:0] digit;
    logic       space;
    logic       plus;
    logic       minus;
    logic       zero;
    logic       xchar;
    logic       last;
  } ch_class_t;

  // finished string handed to the result formatter
  typedef struct packed {
    logic [63:0] acc;
    logic        neg;
    logic        rng;
    logic        bad;
    logic        sgn;
    logic [11:0] cnt;
  } raw_res_t;

endpackage

FILE: hdl/atoi_front.sv
module atoi_front
  import atoi_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  logic [7:0] ch_i,
  input  logic      last_i,
  output logic      q_valid_o,
  output ch_class_t q_item_o,
  input  logic      q_pop_i
);

  ch_class_t        cls;
  ch_class_t        mem_q [QDEPTH];
  logic [QAW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [QAW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [QAW:0]     cnt_q, cnt_d;
  logic             push;
  logic             pop;

  always_comb begin
    cls.digit = NO_DIGIT;
    if (ch_i >= CH_ZERO && ch_i <= CH_NINE) begin
      cls.digit = 6'(ch_i - CH_ZERO);
    end else if (ch_i >= CH_LA && ch_i <= CH_LZ) begin
      cls.digit = 6'(ch_i - CH_LA + 8'd10);
    end else if (ch_i >= CH_UA && ch_i <= CH_UZ) begin
      cls.digit = 6'(ch_i - CH_UA + 8'd10);
    end
    cls.space = (ch_i == CH_SPACE) || (ch_i >= CH_TAB && ch_i <= CH_CR);
    cls.plus  = (ch_i == CH_PLUS);
    cls.minus = (ch_i == CH_MINUS);
    cls.zero  = (ch_i == CH_ZERO);
    cls.xchar = (ch_i == CH_LX) || (ch_i == CH_UX);
    cls.last  = last_i;
  end

  assign in_ready_o = (cnt_q != (QAW+1)'(QDEPTH));
  assign push       = in_valid_i && in_ready_o;
  assign q_valid_o  = (cnt_q != '0);
  assign pop        = q_pop_i && q_valid_o;
  assign q_item_o   = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= cls;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

FILE: hdl/atoi_back.sv
module atoi_back
  import atoi_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_idx_i,
  input  logic [5:0] cfg_data_i,
  input  logic       q_valid_i,
  input  ch_class_t  q_item_i,
  output logic       q_pop_o,
  output logic       res_valid_o,
  output raw_res_t   res_o,
  input  logic       res_ready_i
);

  logic [5:0]  number_base_q;
  logic        signed_mode_q;

  phase_e      phase_q, phase_d;
  logic [63:0] acc_q, acc_d;
  logic        neg_q, neg_d;
  logic [5:0]  base_q, base_d;
  logic [11:0] cnt_q, cnt_d;
  logic        rng_q, rng_d;
  logic [11:0] pos_q, pos_d;

  logic        res_valid_q, res_valid_d;
  raw_res_t    res_q, res_d;

  phase_e      ph_cur, phase_n;
  logic [5:0]  base_cur, base_n, base_s, mul_base;
  logic [63:0] acc_n;
  logic        neg_n, rng_n;
  logic [11:0] cnt_n, pos_next;
  logic        start, take, cfg_bad;
  logic [69:0] prod;
  logic        res_free;
  logic        go;

  assign cfg_bad  = (number_base_q == BASE_ONE) || (number_base_q > BASE_MAX);
  assign base_cur = (phase_q == PH_FRESH) ? number_base_q : base_q;
  assign ph_cur   = (phase_q == PH_FRESH) ? (cfg_bad ? PH_DONE : PH_SPACE) : phase_q;
  assign pos_next = (pos_q < MAX_CHARS) ? pos_q + 12'd1 : MAX_CHARS;

  // radix that the digit of this character is weighed with
  always_comb begin
    mul_base = base_cur;
    if (ph_cur == PH_ZERO) begin
      mul_base = (base_cur == BASE_AUTO) ? BASE_OCT : BASE_HEX;
    end else if (ph_cur == PH_PREFIX) begin
      mul_base = BASE_HEX;
    end
  end

  // a carry into the top bits marks overflow of the 64-bit accumulator
  assign prod = 70'(acc_q) * 70'(mul_base) + 70'(q_item_i.digit);

  always_comb begin
    phase_n = ph_cur;
    base_n  = base_cur;
    base_s  = base_cur;
    acc_n   = acc_q;
    neg_n   = neg_q;
    cnt_n   = cnt_q;
    rng_n   = rng_q;
    start   = 1'b0;
    take    = 1'b0;
    case (ph_cur)
      PH_SPACE: begin
        if (q_item_i.space) begin
          phase_n = PH_SPACE;
        end else if (q_item_i.plus) begin
          phase_n = PH_SIGNED;
        end else if (q_item_i.minus) begin
          neg_n   = 1'b1;
          phase_n = PH_SIGNED;
        end else begin
          start = 1'b1;
        end
      end
      PH_SIGNED: begin
        start = 1'b1;
      end
      PH_ZERO: begin
        if (q_item_i.xchar) begin
          phase_n = PH_PREFIX;
        end else begin
          base_n = mul_base;
          if (q_item_i.digit < mul_base) begin
            take = 1'b1;
          end else begin
            phase_n = PH_DONE;
          end
        end
      end
      PH_PREFIX: begin
        base_n = BASE_HEX;
        if (q_item_i.digit < BASE_HEX) begin
          take = 1'b1;
        end else begin
          phase_n = PH_DONE;
        end
      end
      PH_DIGITS: begin
        if (q_item_i.digit < base_cur) begin
          take = 1'b1;
        end else begin
          phase_n = PH_DONE;
        end
      end
      default: begin
        phase_n = ph_cur;
      end
    endcase

    if (start) begin
      if ((base_cur == BASE_AUTO || base_cur == BASE_HEX) && q_item_i.zero) begin
        acc_n   = '0;
        cnt_n   = pos_next;
        phase_n = PH_ZERO;
      end else begin
        base_s = (base_cur == BASE_AUTO) ? BASE_DEC : base_cur;
        base_n = base_s;
        if (q_item_i.digit < base_s) begin
          acc_n   = 64'(q_item_i.digit);
          cnt_n   = pos_next;
          phase_n = PH_DIGITS;
        end else begin
          phase_n = PH_DONE;
        end
      end
    end

    if (take) begin
      // after overflow the digits are still counted but not accumulated
      if (!rng_q) begin
        if (prod[69:64] != '0) begin
          rng_n = 1'b1;
        end else begin
          acc_n = prod[63:0];
        end
      end
      cnt_n   = pos_next;
      phase_n = PH_DIGITS;
    end
  end

  assign res_free = !res_valid_q || res_ready_i;
  assign go       = q_valid_i && (!q_item_i.last || res_free);
  assign q_pop_o  = go;

  always_comb begin
    phase_d     = phase_q;
    acc_d       = acc_q;
    neg_d       = neg_q;
    base_d      = base_q;
    cnt_d       = cnt_q;
    rng_d       = rng_q;
    pos_d       = pos_q;
    res_valid_d = res_valid_q && !res_ready_i;
    res_d       = res_q;
    if (go) begin
      if (q_item_i.last) begin
        phase_d     = PH_FRESH;
        acc_d       = '0;
        neg_d       = 1'b0;
        base_d      = '0;
        cnt_d       = '0;
        rng_d       = 1'b0;
        pos_d       = '0;
        res_valid_d = 1'b1;
        res_d.acc   = acc_n;
        res_d.neg   = neg_n;
        res_d.rng   = rng_n;
        res_d.bad   = (base_n == BASE_ONE) || (base_n > BASE_MAX);
        res_d.sgn   = signed_mode_q;
        res_d.cnt   = cnt_n;
      end else begin
        phase_d = phase_n;
        acc_d   = acc_n;
        neg_d   = neg_n;
        base_d  = base_n;
        cnt_d   = cnt_n;
        rng_d   = rng_n;
        pos_d   = pos_next;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      number_base_q <= BASE_DEC;
      signed_mode_q <= 1'b1;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CFG_NUMBER_BASE) begin
        number_base_q <= cfg_data_i;
      end else if (cfg_idx_i == CFG_SIGNED_MODE) begin
        signed_mode_q <= cfg_data_i[0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_FRESH;
      acc_q       <= '0;
      neg_q       <= 1'b0;
      base_q      <= '0;
      cnt_q       <= '0;
      rng_q       <= 1'b0;
      pos_q       <= '0;
      res_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      acc_q       <= acc_d;
      neg_q       <= neg_d;
      base_q      <= base_d;
      cnt_q       <= cnt_d;
      rng_q       <= rng_d;
      pos_q       <= pos_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

FILE: hdl/atoi_finish.sv
module atoi_finish
  import atoi_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        res_valid_i,
  input  raw_res_t    res_i,
  output logic        res_ready_o,
  output logic        out_valid_o,
  output logic [79:0] out_data_o,
  input  logic        out_ready_i
);

  logic        out_valid_q, out_valid_d;
  logic [79:0] out_data_q, out_data_d;
  logic [63:0] value, neg_acc;
  status_e     status;
  logic [11:0] cons;
  logic        over;
  logic        load;

  assign neg_acc = 64'd0 - res_i.acc;
  // magnitude beyond the signed limit of the sign at hand
  assign over    = res_i.neg ? (res_i.acc[63] && (res_i.acc[62:0] != '0)) : res_i.acc[63];

  always_comb begin
    value  = res_i.neg ? neg_acc : res_i.acc;
    status = ST_OK;
    cons   = res_i.cnt;
    if (res_i.bad) begin
      value  = '0;
      status = ST_BAD_BASE;
      cons   = '0;
    end else if (res_i.sgn) begin
      if (res_i.rng || over) begin
        value  = res_i.neg ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
        status = ST_RANGE;
      end
    end else if (res_i.rng) begin
      value  = '1;
      status = ST_RANGE;
    end
  end

  assign res_ready_o = !out_valid_q || out_ready_i;
  assign load        = res_valid_i && res_ready_o;

  always_comb begin
    out_valid_d = out_valid_q && !out_ready_i;
    out_data_d  = out_data_q;
    if (load) begin
      out_valid_d = 1'b1;
      out_data_d  = {2'b00, cons, status, value};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

FILE: hdl/ascii_to_integer_parser_top.sv
// text to integer converter, one character per transaction, tlast on the final character
// throughput: one character per cycle while the result output does not stall; back to back strings need no gap
// result path: character queue, then parse step with its 64 x 6 multiply, then the result
//   register of atoi_back and the output register of atoi_finish
// reset: asynchronous active low; clears queue, parse state and result valid,
//   number_base returns to 10 and signed_mode to 1
module ascii_to_integer_parser_top
  import atoi_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [5:0]  cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] ch
  input  logic        s_axis_tlast,   // end_of_text
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [79:0] m_axis_tdata    // [63:0] value_bits, [65:64] status, [77:66] consumed
);

  logic      q_valid;
  ch_class_t q_item;
  logic      q_pop;
  logic      res_valid;
  raw_res_t  res;
  logic      res_ready;

  atoi_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .ch_i       (s_axis_tdata),
    .last_i     (s_axis_tlast),
    .q_valid_o  (q_valid),
    .q_item_o   (q_item),
    .q_pop_i    (q_pop)
  );

  atoi_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .q_valid_i   (q_valid),
    .q_item_i    (q_item),
    .q_pop_o     (q_pop),
    .res_valid_o (res_valid),
    .res_o       (res),
    .res_ready_i (res_ready)
  );

  atoi_finish u_finish (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (res_valid),
    .res_i       (res),
    .res_ready_o (res_ready),
    .out_valid_o (m_axis_tvalid),
    .out_data_o  (m_axis_tdata),
    .out_ready_i (m_axis_tready)
  );

endmodule

FILE: hdl/atoi_checker.sv
module atoi_checker
  import atoi_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [79:0] m_axis_tdata
);

  // a stalled result stays offered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped while stalled");

  // status is one of the three defined codes
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[65:64] != 2'd3)
    else $error("undefined status code");

  // invalid base gives zero value and nothing consumed
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[65:64] == ST_BAD_BASE |->
      m_axis_tdata[63:0] == 64'd0 && m_axis_tdata[77:66] == 12'd0)
    else $error("invalid base result not cleared");

  // overflow needs at least one accepted digit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[65:64] == ST_RANGE |-> m_axis_tdata[77:66] != 12'd0)
    else $error("range status without consumed characters");

endmodule

bind ascii_to_integer_parser_top atoi_checker u_atoi_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
